// File: rtl/core/command_frame_builder_core_assert.svh
// Assertion macros shared by the command frame builder RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef COMMAND_FRAME_BUILDER_CORE_ASSERT_SVH
`define COMMAND_FRAME_BUILDER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define CFB_ASSERT_HOLDS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("cfb assertion failed");
`define CFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cfb assertion failed");
`else
`define CFB_ASSERT_HOLDS(lbl, clk, rstn, cond)
`define CFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/cfb_pkg.sv
// Package for the command frame builder: frame constants, opcodes and types.
// No dependencies; used by the serializer, the top level and the testbench.
package cfb_pkg;

  localparam int HDR_LEN   = 25;
  localparam int FRAME_MAX = 29;
  localparam int CNT_W     = $clog2(FRAME_MAX + 1);

  localparam logic [8:0] MAX_PAYLOAD = 9'd256;

  localparam logic OP_HEADER  = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  typedef logic [FRAME_MAX-1:0][7:0] frame_bytes_t;
  typedef logic [CNT_W-1:0] byte_cnt_t;

  typedef struct packed {
    byte_cnt_t cnt;
    logic      end_flag;
  } load_ctl_t;

endpackage

// File: rtl/core/cfb_if.sv
// Valid/ready channel interfaces for the command frame builder.
// Depends on nothing but plain logic types.
interface cfb_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] command;
  logic [31:0] param_one;
  logic [31:0] param_two;
  logic [8:0]  payload_size;
  logic        has_payload;
  logic [7:0]  data_byte;

  modport source (output valid, opcode, command, param_one, param_two, payload_size,
                  has_payload, data_byte, input ready);
  modport sink (input valid, opcode, command, param_one, param_two, payload_size,
                has_payload, data_byte, output ready);
endinterface

interface cfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, out_byte, frame_end, input ready);
  modport sink (input valid, out_byte, frame_end, output ready);
endinterface

// File: rtl/core/command_frame_builder_core.sv
// Command frame builder top level. A header item yields 25 bytes (29 with an
// empty payload), a payload byte yields 1 or 5 bytes, one byte per cycle when not
// stalled, through the shift line and output register in cfb_serializer.
// The next item is taken in the cycle the last byte of the previous one moves on.
// Synchronous active-low reset clears payload state, the start byte and all valids.
`include "command_frame_builder_core_assert.svh"

module command_frame_builder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  cfb_in_if.sink     in_ch,
  cfb_out_if.source  out_ch
);

  logic        hdr_accept;
  logic [7:0]  start_byte_r;
  logic        in_payload_r, in_payload_nxt;
  logic [8:0]  bytes_left_r, bytes_left_nxt;
  logic [31:0] payload_sum_r, payload_sum_nxt;

  logic                  can_load;
  logic                  accept;
  logic [8:0]            size_sat;
  logic [11:0]           hdr_sum;
  logic [31:0]           size_word;
  logic [31:0]           hdr_sum_word;
  logic [31:0]           sum_new;
  logic                  last_byte;
  cfb_pkg::load_ctl_t    load_ctl;
  cfb_pkg::frame_bytes_t load_bytes;

  function automatic logic [9:0] word_byte_sum(input logic [31:0] w);
    return {2'b00, w[31:24]} + {2'b00, w[23:16]} + {2'b00, w[15:8]} + {2'b00, w[7:0]};
  endfunction

  assign accept   = in_ch.valid && can_load;
  assign in_ch.ready = can_load;
  assign hdr_accept = accept && (in_ch.opcode == cfb_pkg::OP_HEADER);

  always_comb begin
    size_sat = (in_ch.payload_size > cfb_pkg::MAX_PAYLOAD) ? cfb_pkg::MAX_PAYLOAD
                                                            : in_ch.payload_size;
    size_word = {23'd0, size_sat};
    hdr_sum  = {2'b00, word_byte_sum(in_ch.command)} +
               {2'b00, word_byte_sum(in_ch.param_one)} +
               {2'b00, word_byte_sum(in_ch.param_two)} +
               {11'd0, size_sat[8]} + {4'd0, size_sat[7:0]};
    hdr_sum_word = {20'd0, hdr_sum};
    sum_new   = payload_sum_r + {24'd0, in_ch.data_byte};
    last_byte = (bytes_left_r == 9'd1);

    load_bytes      = '0;
    load_ctl        = '0;
    in_payload_nxt  = in_payload_r;
    bytes_left_nxt  = bytes_left_r;
    payload_sum_nxt = payload_sum_r;

    if (in_ch.opcode == cfb_pkg::OP_HEADER) begin
      load_bytes[0] = start_byte_r;
      for (int k = 0; k < 4; k++) begin
        load_bytes[1 + k]  = in_ch.command[8*(3-k) +: 8];
        load_bytes[5 + k]  = in_ch.param_one[8*(3-k) +: 8];
        load_bytes[9 + k]  = in_ch.param_two[8*(3-k) +: 8];
        load_bytes[13 + k] = size_word[8*(3-k) +: 8];
        load_bytes[21 + k] = hdr_sum_word[8*(3-k) +: 8];
      end
      if (in_ch.has_payload && (size_sat == 9'd0)) begin
        load_ctl.cnt = cfb_pkg::byte_cnt_t'(cfb_pkg::FRAME_MAX);
      end else begin
        load_ctl.cnt = cfb_pkg::byte_cnt_t'(cfb_pkg::HDR_LEN);
      end
      load_ctl.end_flag = !in_ch.has_payload || (size_sat == 9'd0);
      in_payload_nxt    = in_ch.has_payload && (size_sat != 9'd0);
      bytes_left_nxt    = in_ch.has_payload ? size_sat : 9'd0;
      payload_sum_nxt   = '0;
    end else if (in_payload_r) begin
      load_bytes[0] = in_ch.data_byte;
      for (int k = 0; k < 4; k++) begin
        load_bytes[1 + k] = sum_new[8*(3-k) +: 8];
      end
      load_ctl.cnt      = last_byte ? cfb_pkg::byte_cnt_t'(5) : cfb_pkg::byte_cnt_t'(1);
      load_ctl.end_flag = last_byte;
      bytes_left_nxt    = bytes_left_r - 9'd1;
      if (last_byte) begin
        in_payload_nxt  = 1'b0;
        payload_sum_nxt = '0;
      end else begin
        payload_sum_nxt = sum_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r  <= '0;
      in_payload_r  <= 1'b0;
      bytes_left_r  <= '0;
      payload_sum_r <= '0;
    end else begin
      if (cfg_we) begin
        start_byte_r <= cfg_wdata;
      end
      if (accept) begin
        in_payload_r  <= in_payload_nxt;
        bytes_left_r  <= bytes_left_nxt;
        payload_sum_r <= payload_sum_nxt;
      end
    end
  end

  cfb_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .load_ctl   (load_ctl),
    .load_bytes (load_bytes),
    .can_load   (can_load),
    .out_ch     (out_ch)
  );

  `CFB_ASSERT_HOLDS(a_open_has_count, clk, rst_n, !in_payload_r || (bytes_left_r != 9'd0))
  `CFB_ASSERT_HOLDS(a_closed_sum_zero, clk, rst_n, in_payload_r || (payload_sum_r == 32'd0))
  `CFB_ASSERT_NEXT(a_header_closes_or_opens, clk, rst_n, hdr_accept, in_payload_r == $past(in_payload_nxt))

endmodule

// File: rtl/core/cfb_serializer.sv
// Byte serializer: a loadable shift line of frame bytes and the output register.
// Depends on cfb_pkg, cfb_out_if and the assertion macro header.
`include "command_frame_builder_core_assert.svh"

module cfb_serializer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  cfb_pkg::load_ctl_t   load_ctl,
  input  cfb_pkg::frame_bytes_t load_bytes,
  output logic                 can_load,
  cfb_out_if.source            out_ch
);

  cfb_pkg::frame_bytes_t bytes_r, bytes_nxt;
  cfb_pkg::byte_cnt_t    cnt_r, cnt_nxt;
  logic                  end_r, end_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_byte_r, out_byte_nxt;
  logic                  out_end_r, out_end_nxt;
  logic                  advance;

  always_comb begin
    advance  = (cnt_r != '0) && (!out_valid_r || out_ch.ready);
    can_load = (cnt_r == '0) ||
               ((cnt_r == cfb_pkg::byte_cnt_t'(1)) && advance);

    bytes_nxt     = bytes_r;
    cnt_nxt       = cnt_r;
    end_nxt       = end_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_end_nxt   = out_end_r;

    if (advance) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = bytes_r[0];
      out_end_nxt   = end_r && (cnt_r == cfb_pkg::byte_cnt_t'(1));
      bytes_nxt     = cfb_pkg::frame_bytes_t'(bytes_r >> 8);
      cnt_nxt       = cnt_r - cfb_pkg::byte_cnt_t'(1);
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (load) begin
      bytes_nxt = load_bytes;
      cnt_nxt   = load_ctl.cnt;
      end_nxt   = load_ctl.end_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      end_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      end_r       <= end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r    <= bytes_nxt;
    out_byte_r <= out_byte_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.frame_end = out_end_r;

  `CFB_ASSERT_HOLDS(a_cnt_range, clk, rst_n, cnt_r <= cfb_pkg::byte_cnt_t'(cfb_pkg::FRAME_MAX))
  `CFB_ASSERT_HOLDS(a_load_when_free, clk, rst_n, !load || can_load)

endmodule

// File: sim/command_frame_builder_core_tb.sv
// Self-checking testbench for command_frame_builder_core: directed and random frames,
// predicted byte streams checked against every output transfer, with random stalls in all but the last phase.
// Depends on cfb_pkg and the cfb_in_if / cfb_out_if channel interfaces.
module command_frame_builder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic        opcode;
    logic [31:0] command;
    logic [31:0] param_one;
    logic [31:0] param_two;
    logic [8:0]  payload_size;
    logic        has_payload;
    logic [7:0]  data_byte;
  } frame_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  cfb_in_if  in_ch ();
  cfb_out_if out_ch ();

  command_frame_builder_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  frame_item_t tx_items[$];
  frame_item_t cur_item;
  frame_byte_t expected_bytes[$];
  frame_byte_t want_byte;

  logic [7:0]  start_val;
  logic        pay_open;
  logic [8:0]  pay_left;
  logic [31:0] pay_sum;

  int send_idle_pct;
  int recv_idle_pct;
  int err_count;
  int in_count;
  int out_count;
  int setting_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void push_frame_byte(logic [7:0] b, logic last);
    frame_byte_t fb;
    fb.data = b;
    fb.last = last;
    expected_bytes.push_back(fb);
  endfunction

  function automatic logic [31:0] push_be_word(logic [31:0] w, logic last);
    logic [31:0] bsum;
    bsum = '0;
    for (int k = 3; k >= 0; k--) begin
      push_frame_byte(w[8*k +: 8], last && (k == 0));
      bsum += {24'd0, w[8*k +: 8]};
    end
    return bsum;
  endfunction

  function automatic void predict_frame_bytes(frame_item_t it);
    logic [8:0]  size;
    logic [31:0] hdr_sum;
    if (it.opcode == cfb_pkg::OP_HEADER) begin
      size = (it.payload_size > cfb_pkg::MAX_PAYLOAD) ? cfb_pkg::MAX_PAYLOAD
                                                       : it.payload_size;
      pay_open = 1'b0;
      pay_left = '0;
      pay_sum  = '0;
      push_frame_byte(start_val, 1'b0);
      hdr_sum = push_be_word(it.command, 1'b0);
      hdr_sum += push_be_word(it.param_one, 1'b0);
      hdr_sum += push_be_word(it.param_two, 1'b0);
      hdr_sum += push_be_word({23'd0, size}, 1'b0);
      hdr_sum += push_be_word(32'd0, 1'b0);
      void'(push_be_word(hdr_sum, !it.has_payload));
      if (it.has_payload) begin
        if (size == 0) begin
          void'(push_be_word(32'd0, 1'b1));
        end else begin
          pay_open = 1'b1;
          pay_left = size;
        end
      end
    end else if (pay_open) begin
      push_frame_byte(it.data_byte, 1'b0);
      pay_sum += {24'd0, it.data_byte};
      if (pay_left != 0) begin
        pay_left--;
      end
      if (pay_left == 0) begin
        void'(push_be_word(pay_sum, 1'b1));
        pay_open = 1'b0;
        pay_sum  = '0;
      end
    end
  endfunction

  function automatic frame_item_t make_header(logic [31:0] cmd, logic [31:0] p1,
                                              logic [31:0] p2, logic [8:0] size,
                                              logic has);
    frame_item_t it;
    it.opcode       = cfb_pkg::OP_HEADER;
    it.command      = cmd;
    it.param_one    = p1;
    it.param_two    = p2;
    it.payload_size = size;
    it.has_payload  = has;
    it.data_byte    = 8'($urandom_range(255));
    return it;
  endfunction

  function automatic frame_item_t make_payload_byte(logic [7:0] b);
    frame_item_t it;
    it.opcode       = cfb_pkg::OP_PAYLOAD;
    it.command      = $urandom();
    it.param_one    = $urandom();
    it.param_two    = $urandom();
    it.payload_size = 9'($urandom_range(511));
    it.has_payload  = 1'($urandom_range(1));
    it.data_byte    = b;
    return it;
  endfunction

  function automatic frame_item_t random_header(logic [8:0] size, logic has);
    return make_header($urandom(), $urandom(), $urandom(), size, has);
  endfunction

  // Driver: once the previous item has transferred, a new item is presented unless the send_idle_pct roll holds it off.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_frame_bytes(cur_item);
        in_count++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = tx_items.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.opcode       <= cur_item.opcode;
          in_ch.command      <= cur_item.command;
          in_ch.param_one    <= cur_item.param_one;
          in_ch.param_two    <= cur_item.param_two;
          in_ch.payload_size <= cur_item.payload_size;
          in_ch.has_payload  <= cur_item.has_payload;
          in_ch.data_byte    <= cur_item.data_byte;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_ch.valid && out_ch.ready) begin
        out_count++;
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte: expected none, actual byte %h end %b",
                   $time, out_ch.out_byte, out_ch.frame_end);
          err_count++;
        end else begin
          want_byte = expected_bytes.pop_front();
          if (want_byte.data !== out_ch.out_byte) begin
            $display("%0t: out_byte mismatch: expected %h, actual %h",
                     $time, want_byte.data, out_ch.out_byte);
            err_count++;
          end
          if (want_byte.last !== out_ch.frame_end) begin
            $display("%0t: frame_end mismatch: expected %b, actual %b",
                     $time, want_byte.last, out_ch.frame_end);
            err_count++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  task automatic write_start_byte(input logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    start_val = v;
    setting_count++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued item has transferred and every expected byte has arrived.
  task automatic drain();
    do begin
      @(negedge clk);
    end while (tx_items.size() != 0 || in_ch.valid || expected_bytes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_directed();
    tx_items.push_back(make_payload_byte(8'hFF));
    tx_items.push_back(make_header(32'h0, 32'h0, 32'h0, 9'd0, 1'b0));
    tx_items.push_back(make_header(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   9'h1FF, 1'b0));
    tx_items.push_back(random_header(9'd0, 1'b1));
    tx_items.push_back(random_header(9'd2, 1'b1));
    tx_items.push_back(make_payload_byte(8'h00));
    tx_items.push_back(make_payload_byte(8'hFF));
    tx_items.push_back(random_header(9'd256, 1'b1));
    tx_items.push_back(make_payload_byte(8'hFF));
    tx_items.push_back(make_payload_byte(8'h80));
    tx_items.push_back(random_header(9'd1, 1'b1));
    tx_items.push_back(make_payload_byte(8'h7F));
    tx_items.push_back(make_payload_byte(8'h55));
    tx_items.push_back(random_header(9'd300, 1'b1));
    tx_items.push_back(make_payload_byte(8'h01));
    tx_items.push_back(random_header(9'd5, 1'b0));
    tx_items.push_back(make_payload_byte(8'hAA));
    tx_items.push_back(make_header(32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
                                   9'd3, 1'b1));
    tx_items.push_back(make_payload_byte(8'hFE));
    tx_items.push_back(make_payload_byte(8'hFD));
    tx_items.push_back(make_payload_byte(8'hFC));
  endtask

  // Mostly complete payload frames; the rest are bare headers, cut-off payloads
  // and stray payload bytes.
  task automatic queue_random_frames(input int target);
    int made;
    int roll;
    int size;
    int cut;
    made = 0;
    while (made < target) begin
      roll = $urandom_range(99);
      if (roll < 75) begin
        roll = $urandom_range(99);
        if (roll < 10) begin
          size = 0;
        end else if (roll < 85) begin
          size = $urandom_range(1, 8);
        end else begin
          size = $urandom_range(9, 40);
        end
        tx_items.push_back(random_header(9'(size), 1'b1));
        for (int i = 0; i < size; i++) begin
          tx_items.push_back(make_payload_byte(8'($urandom_range(255))));
        end
        made += 1 + size;
      end else if (roll < 87) begin
        tx_items.push_back(random_header(9'($urandom_range(511)), 1'b0));
        made++;
      end else if (roll < 95) begin
        cut = $urandom_range(3);
        tx_items.push_back(random_header(9'($urandom_range(4, 511)), 1'b1));
        for (int i = 0; i < cut; i++) begin
          tx_items.push_back(make_payload_byte(8'($urandom_range(255))));
        end
        made += 1 + cut;
      end else begin
        tx_items.push_back(make_payload_byte(8'($urandom_range(255))));
        made++;
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = cfb_pkg::OP_HEADER;
    in_ch.command      = '0;
    in_ch.param_one    = '0;
    in_ch.param_two    = '0;
    in_ch.payload_size = '0;
    in_ch.has_payload  = 1'b0;
    in_ch.data_byte    = '0;
    out_ch.ready       = 1'b0;
    start_val          = '0;
    pay_open           = 1'b0;
    pay_left           = '0;
    pay_sum            = '0;
    send_idle_pct      = 37;
    recv_idle_pct      = 81;
    err_count          = 0;
    in_count           = 0;
    out_count          = 0;
    setting_count      = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    tx_items.push_back(make_payload_byte(8'h3C));
    tx_items.push_back(random_header(9'd7, 1'b0));
    drain();

    write_start_byte(8'hFF);
    @(negedge clk);
    queue_directed();
    drain();

    write_start_byte(8'h00);
    @(negedge clk);
    queue_random_frames(50);
    drain();

    write_start_byte(8'($urandom_range(1, 254)));
    @(negedge clk);
    send_idle_pct = 81;
    recv_idle_pct = 37;
    queue_random_frames(50);
    drain();

    write_start_byte(8'($urandom_range(255)));
    @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_frames(50);
    drain();

    $display("Run covered %0d input transfers and %0d output bytes over %0d start byte values,",
             in_count, out_count, setting_count + 1);
    $display("including empty, oversized, abandoned and stray payload cases.");
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
